>>> sv/assert_macros.svh
// Assertion helpers used by the RTL core of the classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lsdc_pkg.sv
`timescale 1ns / 1ps

package lsdc_pkg;

   localparam int MAX_DIRECTIONS_DEF  = 32;
   localparam int MAX_FEATURES_DEF    = 64;
   localparam int SIGMOID_ENTRIES_DEF = 256;

   // Input operation codes.
   localparam logic OP_MODEL  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Model word kinds.
   localparam logic [1:0] KIND_WEIGHT = 2'd0;
   localparam logic [1:0] KIND_BIAS   = 2'd1;
   localparam logic [1:0] KIND_OFFSET = 2'd2;
   localparam logic [1:0] KIND_SLOPE  = 2'd3;

   // Configuration register indexes.
   localparam logic REG_DIRECTIONS = 1'b0;
   localparam logic REG_FEATURES   = 1'b1;

   localparam logic [5:0] DIRECTIONS_RESET = 6'd32;
   localparam logic [6:0] FEATURES_RESET   = 7'd64;

   localparam logic signed [5:0]  BEST_NONE = -6'sd1;
   localparam logic signed [15:0] ARG_MAX   = 16'sh7fff;
   localparam logic signed [15:0] ARG_MIN   = 16'sh8000;

   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   // Restoring shift-subtract division, used only to build constant tables.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // e^-x in Q0.30 for x in Q.12, 0 <= x <= 4096, by a truncating Taylor series.
   function automatic logic [63:0] exp_neg_frac(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      term = ONE_Q30;
      sum  = $signed(ONE_Q30);
      for (int k = 1; k <= 16; k++) begin
         term = udiv64((term * x) >> 12, 64'(k));
         if ((k & 1) != 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      return sum;
   endfunction

   // Sigmoid in Q0.16 of a Q4.12 argument with magnitude up to 8.
   function automatic logic [15:0] sigmoid_q16(input logic signed [63:0] a);
      logic [63:0] mag;
      logic [63:0] n;
      logic [63:0] e1;
      logic [63:0] e;
      logic [63:0] d;
      logic [63:0] p;
      mag = (a < 0) ? 64'(-a) : 64'(a);
      n   = mag >> 12;
      e1  = exp_neg_frac(64'd4096);
      e   = exp_neg_frac(mag & 64'hfff);
      for (int i = 0; i < 8; i++) begin
         if (64'(i) < n) begin
            e = (e * e1) >> 30;
         end
      end
      d = ONE_Q30 + e;
      p = udiv64((64'd1 << 46) + (d >> 1), d);
      if (p > 64'd65535) begin
         p = 64'd65535;
      end
      if (a < 0) begin
         p = 64'd65536 - p;
         if (p > 64'd65535) begin
            p = 64'd65535;
         end
      end
      return p[15:0];
   endfunction

   // Table entry i samples the sigmoid at the center of its argument bin.
   function automatic logic [15:0] sig_entry(input int unsigned idx, input int unsigned entries);
      logic signed [63:0] a;
      a = $signed(udiv64(64'(2 * idx + 1) * 64'd32768, 64'(entries))) - 64'sd32768;
      return sigmoid_q16(a);
   endfunction

endpackage

>>> sv/linear_svm_direction_classifier_core.sv
// Model words and feature samples that do not close a vector leave req_ready high. The
// sample that closes a vector holds it low while nd directions of nf products each run,
// and while a finished result waits on rsp_ready; nd and nf are the clamped registers.
// One shared multiplier does one weight-feature product per cycle, then each direction
// drains, rounds, scales, forms its argument, indexes, looks up and emits. A synchronous
// active-high reset clears control and feature count, resets config; memories keep data.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_svm_direction_classifier_core #(
   parameter int MAX_DIRECTIONS  = lsdc_pkg::MAX_DIRECTIONS_DEF,
   parameter int MAX_FEATURES    = lsdc_pkg::MAX_FEATURES_DEF,
   parameter int SIGMOID_ENTRIES = lsdc_pkg::SIGMOID_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [1:0]         req_model_kind,
   input  logic [4:0]         req_direction_index,
   input  logic [5:0]         req_feature_position,
   input  logic signed [15:0] req_sample_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_direction_out,
   output logic [15:0]        rsp_probability,
   output logic               rsp_last_of_run,
   output logic signed [5:0]  rsp_best_direction,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [6:0]         csr_write_data
);

   localparam int D_W     = $clog2(MAX_DIRECTIONS);
   localparam int DC_W    = $clog2(MAX_DIRECTIONS + 1);
   localparam int F_W     = $clog2(MAX_FEATURES);
   localparam int FC_W    = $clog2(MAX_FEATURES + 1);
   localparam int W_DEPTH = MAX_DIRECTIONS * MAX_FEATURES;
   localparam int W_AW    = $clog2(W_DEPTH);
   localparam int S_W     = $clog2(SIGMOID_ENTRIES);
   localparam int ACC_W   = 32 + FC_W;
   localparam int SC_W    = ACC_W - 15;
   localparam int P_W     = SC_W + 16;
   localparam int AR_W    = P_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_SCALE,
      ST_ARG,
      ST_INDEX,
      ST_LOOKUP,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [5:0]      dir_use_ff;
   logic [6:0]      feat_use_ff;
   logic [DC_W-1:0] nd_eff;
   logic [FC_W-1:0] nf_eff;

   logic [F_W-1:0] feat_cnt_ff;
   logic [F_W-1:0] j_ff;
   logic [D_W-1:0] dir_ff;
   logic [D_W-1:0] best_idx_ff;
   logic [15:0]    best_p_ff;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [4:0]        rsp_dir_ff;
   logic [15:0]       rsp_prob_ff;
   logic              rsp_last_ff;
   logic signed [5:0] rsp_best_ff;
   logic signed [5:0] rsp_best_in;

   logic req_accept;
   logic model_wr;
   logic sample_wr;
   logic dir_ok;
   logic pos_ok;
   logic vec_done;
   logic j_last;
   logic dir_last;
   logic out_free;
   logic better;

   logic [D_W-1:0]  wr_dir;
   logic [F_W-1:0]  wr_pos;
   logic [W_AW-1:0] wr_waddr;
   logic [W_AW-1:0] rd_waddr;

   logic signed [15:0] weight_mem [W_DEPTH];
   logic signed [15:0] feat_mem   [MAX_FEATURES];
   logic signed [15:0] bias_mem   [MAX_DIRECTIONS];
   logic signed [15:0] offset_mem [MAX_DIRECTIONS];
   logic signed [15:0] slope_mem  [MAX_DIRECTIONS];

   logic signed [15:0] w_rd_ff;
   logic signed [15:0] f_rd_ff;
   logic signed [15:0] bias_rd_ff;
   logic signed [15:0] offset_rd_ff;
   logic signed [15:0] slope_rd_ff;

   logic rd_vld_ff;
   logic rd_first_ff;
   logic rd_last_ff;
   logic prod_vld_ff;
   logic prod_first_ff;
   logic prod_last_ff;

   logic signed [SC_W-1:0]  mul_a;
   logic signed [15:0]      mul_b;
   logic signed [P_W-1:0]   mul_p;
   logic signed [P_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0] bias_acc;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [SC_W-1:0]  score_ff;
   logic signed [SC_W-1:0]  score_in;
   logic signed [AR_W-1:0]  arg_sum;
   logic signed [15:0]      arg_ff;
   logic signed [15:0]      arg_in;
   logic [15:0]             arg_u;
   logic [S_W-1:0]          idx_ff;
   logic [S_W-1:0]          idx_in;
   logic [15:0]             prob;

   // Register clamping.
   always_comb begin
      if (dir_use_ff == 6'd0) begin
         nd_eff = DC_W'(1);
      end else if (32'(dir_use_ff) > 32'(MAX_DIRECTIONS)) begin
         nd_eff = DC_W'(MAX_DIRECTIONS);
      end else begin
         nd_eff = DC_W'(dir_use_ff);
      end
      if (feat_use_ff == 7'd0) begin
         nf_eff = FC_W'(1);
      end else if (32'(feat_use_ff) > 32'(MAX_FEATURES)) begin
         nf_eff = FC_W'(MAX_FEATURES);
      end else begin
         nf_eff = FC_W'(feat_use_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_use_ff  <= lsdc_pkg::DIRECTIONS_RESET;
         feat_use_ff <= lsdc_pkg::FEATURES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            lsdc_pkg::REG_DIRECTIONS: begin
               dir_use_ff <= csr_write_data[5:0];
            end
            lsdc_pkg::REG_FEATURES: begin
               feat_use_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign model_wr   = req_accept && (req_op == lsdc_pkg::OP_MODEL);
   assign sample_wr  = req_accept && (req_op == lsdc_pkg::OP_SAMPLE);
   assign dir_ok     = 32'(req_direction_index) < 32'(MAX_DIRECTIONS);
   assign pos_ok     = 32'(req_feature_position) < 32'(MAX_FEATURES);
   assign wr_dir     = D_W'(req_direction_index);
   assign wr_pos     = F_W'(req_feature_position);
   assign wr_waddr   = W_AW'(wr_dir) * W_AW'(MAX_FEATURES) + W_AW'(wr_pos);
   assign rd_waddr   = W_AW'(dir_ff) * W_AW'(MAX_FEATURES) + W_AW'(j_ff);

   assign vec_done = (FC_W'(feat_cnt_ff) + FC_W'(1)) >= nf_eff;
   assign j_last   = (FC_W'(j_ff) + FC_W'(1)) == nf_eff;
   assign dir_last = (DC_W'(dir_ff) + DC_W'(1)) == nd_eff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign better   = prob > best_p_ff;

   // The result register loads in the emit state and empties when its beat is taken.
   assign rsp_valid_in = ((state_ff == ST_OUT) && out_free) || (rsp_valid_ff && !rsp_ready);

   // Memories: written while idle, read every cycle at the sequencer's address.
   always_ff @(posedge clock) begin
      if (model_wr && dir_ok && pos_ok && (req_model_kind == lsdc_pkg::KIND_WEIGHT)) begin
         weight_mem[wr_waddr] <= req_sample_value;
      end
      w_rd_ff <= weight_mem[rd_waddr];
   end

   always_ff @(posedge clock) begin
      if (sample_wr) begin
         feat_mem[feat_cnt_ff] <= req_sample_value;
      end
      f_rd_ff <= feat_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (model_wr && dir_ok && (req_model_kind == lsdc_pkg::KIND_BIAS)) begin
         bias_mem[wr_dir] <= req_sample_value;
      end
      bias_rd_ff <= bias_mem[dir_ff];
   end

   always_ff @(posedge clock) begin
      if (model_wr && dir_ok && (req_model_kind == lsdc_pkg::KIND_OFFSET)) begin
         offset_mem[wr_dir] <= req_sample_value;
      end
      offset_rd_ff <= offset_mem[dir_ff];
   end

   always_ff @(posedge clock) begin
      if (model_wr && dir_ok && (req_model_kind == lsdc_pkg::KIND_SLOPE)) begin
         slope_mem[wr_dir] <= req_sample_value;
      end
      slope_rd_ff <= slope_mem[dir_ff];
   end

   // The one multiplier serves the dot product and then the slope scaling.
   assign mul_a = (state_ff == ST_SCALE) ? score_ff : SC_W'(w_rd_ff);
   assign mul_b = (state_ff == ST_SCALE) ? slope_rd_ff : f_rd_ff;
   assign mul_p = P_W'(mul_a) * P_W'(mul_b);

   assign bias_acc = ACC_W'($signed({bias_rd_ff, 15'd0}));
   assign acc_in   = (prod_first_ff ? bias_acc : acc_ff) + ACC_W'(prod_ff);
   assign acc_rnd  = acc_ff + ACC_W'(16384);
   assign score_in = acc_rnd[ACC_W-1:15];

   // Adding one half before the shift only sets bit 11 of the shifted offset.
   always_comb begin
      arg_sum = AR_W'($signed({offset_rd_ff, 12'h800})) + AR_W'(prod_ff);
      if ((&arg_sum[AR_W-1:27]) || !(|arg_sum[AR_W-1:27])) begin
         arg_in = arg_sum[27:12];
      end else if (arg_sum[AR_W-1]) begin
         arg_in = lsdc_pkg::ARG_MIN;
      end else begin
         arg_in = lsdc_pkg::ARG_MAX;
      end
   end

   assign arg_u  = {~arg_ff[15], arg_ff[14:0]};
   assign idx_in = S_W'((32'(arg_u) * 32'(SIGMOID_ENTRIES)) >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= (state_ff == ST_MAC);
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff   <= (state_ff == ST_MAC) && (j_ff == '0);
      rd_last_ff    <= (state_ff == ST_MAC) && j_last;
      prod_first_ff <= rd_first_ff;
      prod_last_ff  <= rd_last_ff;
      if (rd_vld_ff || (state_ff == ST_SCALE)) begin
         prod_ff <= mul_p;
      end
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (state_ff == ST_ROUND) begin
         score_ff <= score_in;
      end
      if (state_ff == ST_ARG) begin
         arg_ff <= arg_in;
      end
      if (state_ff == ST_INDEX) begin
         idx_ff <= idx_in;
      end
   end

   lsdc_sigmoid_rom #(
      .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
   ) u_sigmoid_rom (
      .clock   (clock),
      .rd_en   (state_ff == ST_LOOKUP),
      .rd_idx  (idx_ff),
      .rd_data (prob)
   );

   always_comb begin
      if (!dir_last) begin
         rsp_best_in = 6'sd0;
      end else if (better) begin
         rsp_best_in = 6'(dir_ff);
      end else if (best_p_ff != 16'd0) begin
         rsp_best_in = 6'(best_idx_ff);
      end else begin
         rsp_best_in = lsdc_pkg::BEST_NONE;
      end
   end

   // Sequencer with the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         feat_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (sample_wr) begin
                  if (vec_done) begin
                     feat_cnt_ff <= '0;
                     dir_ff      <= '0;
                     j_ff        <= '0;
                     best_p_ff   <= '0;
                     best_idx_ff <= '0;
                     state_ff    <= ST_MAC;
                  end else begin
                     feat_cnt_ff <= feat_cnt_ff + F_W'(1);
                  end
               end
            end
            ST_MAC: begin
               j_ff <= j_ff + F_W'(1);
               if (j_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (prod_vld_ff && prod_last_ff) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               state_ff <= ST_ARG;
            end
            ST_ARG: begin
               state_ff <= ST_INDEX;
            end
            ST_INDEX: begin
               state_ff <= ST_LOOKUP;
            end
            ST_LOOKUP: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_dir_ff   <= 5'(dir_ff);
                  rsp_prob_ff  <= prob;
                  rsp_last_ff  <= dir_last;
                  rsp_best_ff  <= rsp_best_in;
                  if (better) begin
                     best_p_ff   <= prob;
                     best_idx_ff <= dir_ff;
                  end
                  if (dir_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     dir_ff   <= dir_ff + D_W'(1);
                     j_ff     <= '0;
                     state_ff <= ST_MAC;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_direction_out  = rsp_dir_ff;
   assign rsp_probability    = rsp_prob_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_best_direction = rsp_best_ff;

   `LSDC_ASSERT_NOW(a_pipe_in_dot, clock, reset, rd_vld_ff || prod_vld_ff, state_ff == ST_MAC || state_ff == ST_DRAIN, "product pipeline active outside the dot product")
   `LSDC_ASSERT_NEXT(a_run_ends, clock, reset, state_ff == ST_OUT && out_free && dir_last, state_ff == ST_IDLE && rsp_valid_ff && rsp_last_of_run, "final direction did not close the run")
   `LSDC_ASSERT_NOW(a_best_on_last, clock, reset, rsp_valid_ff && !rsp_last_ff, rsp_best_ff == 6'sd0, "best direction set on a beat that is not last")

endmodule

>>> sv/lsdc_sigmoid_rom.sv
`timescale 1ns / 1ps

module lsdc_sigmoid_rom #(
   parameter int SIGMOID_ENTRIES = lsdc_pkg::SIGMOID_ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               rd_en,
   input  logic [$clog2(SIGMOID_ENTRIES)-1:0] rd_idx,
   output logic [15:0]                        rd_data
);

   logic [15:0] rom [SIGMOID_ENTRIES];
   logic [15:0] rd_data_ff;

   // Entries are worked out at elaboration; the table itself is constant logic.
   for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_entry
      localparam logic [15:0] VALUE =
         lsdc_pkg::sig_entry(32'(g), 32'(SIGMOID_ENTRIES));
      assign rom[g] = VALUE;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
